[hdl/ortm_pkg.sv]
package ortm_pkg;

  // Field widths fixed by the item formats
  localparam int TIME_W    = 48;
  localparam int RATE_W    = 32;
  localparam int GAP_W     = 32;
  localparam int WIN_W     = 7;
  localparam int MARGIN_W  = 20;
  localparam int COUNT_W   = 16;
  localparam int SCALE_W   = 27;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW    = 20;

  // Register reset values and arithmetic constants
  localparam logic [WIN_W-1:0]    WINDOW_RESET = 7'd8;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 20'd0;
  localparam logic [COUNT_W-1:0]  SETTLE_RESET = 16'd8;
  localparam logic [COUNT_W-1:0]  COUNT_MAX    = 16'hFFFF;
  localparam logic [GAP_W-1:0]    GAP_MAX      = 32'hFFFF_FFFF;
  localparam logic [19:0]         RATE_SCALE   = 20'd1000000;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW = 2'd0,
    REG_MARGIN = 2'd1,
    REG_SETTLE = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [TIME_W-1:0] event_time_us;
    logic [RATE_W-1:0] input_rate_q8;
  } in_item_t;

  typedef struct packed {
    logic raise_request;
    logic compared;
  } out_item_t;

  // Per-item control carried alongside the compare pipeline
  typedef struct packed {
    logic counted;   // item advances the settle counter
    logic nonzero;   // interval sum was nonzero
  } cmp_ctl_t;

endpackage

[hdl/ortm_ram.sv]
module ortm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hdl/ortm_rate_cmp.sv]
module ortm_rate_cmp #(
  parameter int SUM_W = 38
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  ortm_pkg::cmp_ctl_t     in_ctl,
  input  logic [31:0]            rate,
  input  logic [SUM_W-1:0]       sum,
  input  logic [19:0]            margin,
  input  logic [26:0]            scale,
  output logic                   out_vld,
  output ortm_pkg::cmp_ctl_t     out_ctl,
  output logic                   out_cand
);

  import ortm_pkg::*;

  localparam int LW = SUM_W + 32;

  logic [31:0] sum_lo;
  logic [31:0] sum_hi;

  logic           c_vld_r;
  cmp_ctl_t       c_ctl_r;
  logic [63:0]    c_rs_lo_r;
  logic [63:0]    c_rs_hi_r;
  logic [51:0]    c_ms_lo_r;
  logic [51:0]    c_ms_hi_r;
  logic [SCALE_W-1:0] c_scale_r;

  logic           d_vld_r;
  cmp_ctl_t       d_ctl_r;
  logic [LW-1:0]  d_lhs_r;
  logic [LW-1:0]  d_rhs_r;
  logic [LW-1:0]  lhs_nxt;
  logic [LW-1:0]  rhs_nxt;
  logic [LW-1:0]  inner;

  assign sum_lo = sum[31:0];
  assign sum_hi = 32'(sum >> 32);

  // Partial products of rate*sum and margin*sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_ctl_r   <= in_ctl;
      c_rs_lo_r <= 64'(rate) * 64'(sum_lo);
      c_rs_hi_r <= 64'(rate) * 64'(sum_hi);
      c_ms_lo_r <= 52'(margin) * 52'(sum_lo);
      c_ms_hi_r <= 52'(margin) * 52'(sum_hi);
      c_scale_r <= scale;
    end
  end

  // Combine into rate*sum and 256*(1e6*window + margin*sum)
  always_comb begin
    lhs_nxt = LW'(c_rs_lo_r) + (LW'(c_rs_hi_r) << 32);
    inner   = LW'(c_scale_r) + LW'(c_ms_lo_r) + (LW'(c_ms_hi_r) << 32);
    rhs_nxt = inner << 8;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (en) begin
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_ctl_r <= c_ctl_r;
      d_lhs_r <= lhs_nxt;
      d_rhs_r <= rhs_nxt;
    end
  end

  // Raise candidate: nonzero sum and input rate above output rate plus margin
  assign out_vld  = d_vld_r;
  assign out_ctl  = d_ctl_r;
  assign out_cand = d_ctl_r.nonzero && (d_lhs_r > d_rhs_r);

endmodule

[hdl/output_rate_throttle_monitor.sv]
// Channel | Direction | Handshake             | Payload
// in_     | input     | in_valid / in_stall   | in_data   (event_time_us, input_rate_q8)
// out_    | output    | out_valid / out_stall | out_data  (raise_request, compared)
// cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_wdata
//
// One item per cycle while out_stall does not hold a valid result; after the input register
// an item passes the ring stage, partial-product, sum-combine and result registers.
// The interval ring is a RAM whose next slot is read ahead through its registered port;
// a wrap flag makes slots not yet written since reset or a window write read as zero.
// Reset is synchronous on rst_n; the block accepts items in the first cycle after it.
// All stages advance together; a stalled result holds the pipeline and in_stall.
module output_rate_throttle_monitor #(
  parameter int WINDOW_MAX = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ortm_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ortm_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ortm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ortm_pkg::CFG_DW-1:0]    cfg_wdata
);

  import ortm_pkg::*;

  localparam int PW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SUM_W = GAP_W + $clog2(WINDOW_MAX);

  // Configuration registers
  logic [WIN_W-1:0]    window_r;
  logic [MARGIN_W-1:0] margin_r;
  logic [COUNT_W-1:0]  settle_r;
  logic                cfg_wr;
  logic                ring_clear;

  // Pipeline control
  logic adv;

  // Input register
  logic     a_vld_r;
  in_item_t a_data_r;

  // Ring state
  logic                  seen_first_r;
  logic [TIME_W-1:0]     prev_time_r;
  logic [PW-1:0]         ptr_r;
  logic [PW-1:0]         ptr_nxt;
  logic [PW:0]           ptr_inc;
  logic                  ptr_wrap;
  logic                  ring_full_r;
  logic [SUM_W-1:0]      sum_r;
  logic [SUM_W-1:0]      sum_nxt;
  logic                  fwd_r;
  logic [GAP_W-1:0]      fwd_data_r;
  logic [GAP_W-1:0]      ram_rdata;
  logic                  ring_we;
  logic [WIN_W-1:0]      w_eff;
  logic [TIME_W-1:0]     diff;
  logic [GAP_W-1:0]      gap;
  logic [GAP_W-1:0]      old_gap;
  logic [SCALE_W-1:0]    scale;

  // Ring stage output
  logic             b_vld_r;
  cmp_ctl_t         b_ctl_r;
  logic [RATE_W-1:0] b_rate_r;
  logic [SUM_W-1:0] b_sum_r;

  // Compare pipeline output
  logic     d_vld;
  cmp_ctl_t d_ctl;
  logic     d_cand;

  // Settle counter and result register
  logic [COUNT_W-1:0] cnt_r;
  logic [COUNT_W-1:0] cnt_inc;
  logic               cmp_now;
  logic               raise_now;
  logic               e_vld_r;
  out_item_t          e_data_r;

  assign adv       = !e_vld_r || !out_stall;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign ring_clear = cfg_wr && (cfg_index == REG_WINDOW);

  // Configuration writes; unknown indexes fall through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
      margin_r <= MARGIN_RESET;
      settle_r <= SETTLE_RESET;
    end else if (cfg_wr) begin
      if (cfg_index == REG_WINDOW) begin
        window_r <= cfg_wdata[WIN_W-1:0];
      end
      if (cfg_index == REG_MARGIN) begin
        margin_r <= cfg_wdata[MARGIN_W-1:0];
      end
      if (cfg_index == REG_SETTLE) begin
        settle_r <= cfg_wdata[COUNT_W-1:0];
      end
    end
  end

  // Capture the input item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_data_r <= in_data;
    end
  end

  // Clamp the window into 1..WINDOW_MAX
  always_comb begin
    if (window_r == '0) begin
      w_eff = WIN_W'(1);
    end else if (32'(window_r) > WINDOW_MAX) begin
      w_eff = WIN_W'(WINDOW_MAX);
    end else begin
      w_eff = window_r;
    end
    scale = SCALE_W'(RATE_SCALE) * SCALE_W'(w_eff);
  end

  // Gap, ring slot replacement and running sum
  always_comb begin
    ring_we = adv && a_vld_r && seen_first_r;
    diff    = a_data_r.event_time_us - prev_time_r;
    gap     = (|diff[TIME_W-1:GAP_W]) ? GAP_MAX : diff[GAP_W-1:0];
    if (!ring_full_r) begin
      old_gap = '0;
    end else if (fwd_r) begin
      old_gap = fwd_data_r;
    end else begin
      old_gap = ram_rdata;
    end
    sum_nxt  = sum_r - SUM_W'(old_gap) + SUM_W'(gap);
    ptr_inc  = {1'b0, ptr_r} + (PW + 1)'(1);
    ptr_wrap = (32'(ptr_inc) >= 32'(w_eff));
    if (ring_clear) begin
      ptr_nxt = '0;
    end else if (ring_we) begin
      ptr_nxt = ptr_wrap ? '0 : ptr_inc[PW-1:0];
    end else begin
      ptr_nxt = ptr_r;
    end
  end

  ortm_ram #(
    .WIDTH(GAP_W),
    .DEPTH(WINDOW_MAX)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ptr_r),
    .wdata (gap),
    .raddr (ptr_nxt),
    .rdata (ram_rdata)
  );

  // Ring control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_first_r <= 1'b0;
      prev_time_r  <= '0;
      ptr_r        <= '0;
      ring_full_r  <= 1'b0;
      sum_r        <= '0;
      fwd_r        <= 1'b0;
    end else begin
      ptr_r <= ptr_nxt;
      fwd_r <= ring_we && (ptr_nxt == ptr_r);
      if (adv && a_vld_r) begin
        seen_first_r <= 1'b1;
        prev_time_r  <= a_data_r.event_time_us;
      end
      if (ring_clear) begin
        ring_full_r <= 1'b0;
        sum_r       <= '0;
      end else if (ring_we) begin
        if (ptr_wrap) begin
          ring_full_r <= 1'b1;
        end
        sum_r <= sum_nxt;
      end
    end
  end

  // Hold the last written gap for a same-slot read
  always_ff @(posedge clk) begin
    if (ring_we) begin
      fwd_data_r <= gap;
    end
  end

  // Ring stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_ctl_r.counted <= seen_first_r;
      b_ctl_r.nonzero <= seen_first_r && (sum_nxt != '0);
      b_rate_r        <= a_data_r.input_rate_q8;
      b_sum_r         <= sum_nxt;
    end
  end

  ortm_rate_cmp #(
    .SUM_W(SUM_W)
  ) u_cmp (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (b_vld_r),
    .in_ctl   (b_ctl_r),
    .rate     (b_rate_r),
    .sum      (b_sum_r),
    .margin   (margin_r),
    .scale    (scale),
    .out_vld  (d_vld),
    .out_ctl  (d_ctl),
    .out_cand (d_cand)
  );

  // Advance the settle counter and decide on a raise
  always_comb begin
    cnt_inc   = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + COUNT_W'(1);
    cmp_now   = d_ctl.counted && (cnt_inc >= settle_r);
    raise_now = cmp_now && d_cand;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      e_vld_r <= 1'b0;
    end else if (adv) begin
      e_vld_r <= d_vld;
      if (d_vld && d_ctl.counted) begin
        cnt_r <= raise_now ? '0 : cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_data_r.raise_request <= raise_now;
      e_data_r.compared      <= cmp_now;
    end
  end

  assign out_valid = e_vld_r;
  assign out_data  = e_data_r;

endmodule
